### hw/rtl/atc_tbd_pkg.sv
// Shared types, constants and channel math for the ATC texture block decoder.
package atc_tbd_pkg;

  localparam int unsigned CFG_W     = 13;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned BX_W      = COORD_W - 2;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned PIX_N     = 16;
  localparam int unsigned PIX_IDX_W = 4;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned IDX_W     = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = 13'd4096;

  typedef enum logic [IDX_W-1:0] {
    REG_RGBA_MODE    = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_idx_e;

  // Selector codes
  localparam logic [1:0] SEL_C0    = 2'd0;
  localparam logic [1:0] SEL_THIRD = 2'd1;
  localparam logic [1:0] SEL_MIX   = 2'd2;
  localparam logic [1:0] SEL_C1    = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] alpha_word;
    logic [WORD_W-1:0] color_word;
    logic [BX_W-1:0]   blk_y;
    logic [BX_W-1:0]   blk_x;
    logic [PIX_N-1:0]  mask;
    logic              rgba;
  } blk_entry_t;

  // Packed so that pixel_x lands in the lowest bits of tdata.
  typedef struct packed {
    logic [CHAN_W-1:0]  alpha;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic [COORD_W-1:0] pixel_y;
    logic [COORD_W-1:0] pixel_x;
  } pixel_t;

  function automatic logic [CHAN_W-1:0] widen5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [CHAN_W-1:0] widen6(logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // floor((2a+b)/3) uses 683/2048; error stays below 1/8 for sums up to 765.
  function automatic logic [CHAN_W-1:0] blend(logic [1:0] code, logic [CHAN_W-1:0] a,
                                               logic [CHAN_W-1:0] b);
    logic [9:0]  t3;
    logic [20:0] prod;
    logic [10:0] t8;
    logic [CHAN_W-1:0] res;
    t3   = {1'b0, a, 1'b0} + {2'b00, b};
    prod = 21'(t3) * 21'd683;
    t8   = 11'(a) * 11'd3 + 11'(b) * 11'd5;
    case (code)
      SEL_C0:    res = a;
      SEL_THIRD: res = prod[18:11];
      SEL_MIX:   res = t8[10:3];
      SEL_C1:    res = b;
      default:   res = b;
    endcase
    return res;
  endfunction

endpackage

### hw/rtl/atc_tbd_front.sv
// Front end: config registers, block walking and per-block pixel clip mask.
module atc_tbd_front import atc_tbd_pkg::*; #(
  parameter int unsigned MAX_IMAGE_DIM = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [WORD_W-1:0] color_word_i,
  input  logic [WORD_W-1:0] alpha_word_i,
  output logic              ent_valid_o,
  input  logic              ent_ready_i,
  output blk_entry_t        ent_o
);

  localparam int unsigned DIM_W = $clog2(MAX_IMAGE_DIM + 1);
  localparam int unsigned BLK_W = $clog2(MAX_IMAGE_DIM) - 1;
  localparam int unsigned CW    = DIM_W + 1;
  localparam int unsigned MW    = (DIM_W > CFG_W) ? DIM_W : CFG_W;

  logic             rgba_q;
  logic [CFG_W-1:0] width_q, height_q;
  logic [BLK_W-1:0] col_q, col_d, row_q, row_d;
  logic [DIM_W-1:0] w_c, h_c, blk_cols, blk_rows;
  logic [3:0]       x_ok, y_ok;
  logic [PIX_N-1:0] mask;
  logic             accept;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_W-1:0] v);
    logic [MW-1:0] ve;
    logic [DIM_W-1:0] res;
    ve = MW'(v);
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (ve > MW'(MAX_IMAGE_DIM)) begin
      res = DIM_W'(MAX_IMAGE_DIM);
    end else begin
      res = ve[DIM_W-1:0];
    end
    return res;
  endfunction

  assign w_c      = clamp_dim(width_q);
  assign h_c      = clamp_dim(height_q);
  assign blk_cols = DIM_W'((CW'(w_c) + CW'(3)) >> 2);
  assign blk_rows = DIM_W'((CW'(h_c) + CW'(3)) >> 2);

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      x_ok[c] = CW'({col_q, c[1:0]}) < CW'(w_c);
      y_ok[c] = CW'({row_q, c[1:0]}) < CW'(h_c);
    end
    for (int p = 0; p < PIX_N; p++) begin
      mask[p] = x_ok[p[1:0]] & y_ok[p[3:2]];
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (CW'(col_q) + CW'(1) >= CW'(blk_cols)) begin
      col_d = '0;
      row_d = (CW'(row_q) + CW'(1) >= CW'(blk_rows)) ? '0 : row_q + BLK_W'(1);
    end else begin
      col_d = col_q + BLK_W'(1);
    end
  end

  assign accept      = in_valid_i && ent_ready_i;
  assign in_ready_o  = ent_ready_i;
  assign ent_valid_o = in_valid_i;

  assign ent_o.alpha_word = alpha_word_i;
  assign ent_o.color_word = color_word_i;
  assign ent_o.blk_x      = BX_W'(col_q);
  assign ent_o.blk_y      = BX_W'(row_q);
  assign ent_o.mask       = mask;
  assign ent_o.rgba       = rgba_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgba_q   <= 1'b0;
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RGBA_MODE:    rgba_q   <= cfg_data_i[0];
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### hw/rtl/atc_tbd_fifo.sv
// Short block queue between the front and back ends.
module atc_tbd_fifo import atc_tbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  blk_entry_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output blk_entry_t pop_data_o
);

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  blk_entry_t       mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_ready_o = cnt_q != CNT_W'(Q_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/atc_tbd_back.sv
// Back end: walks the head block's clip mask; a pixel per cycle unless stalled.
module atc_tbd_back import atc_tbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       ent_valid_i,
  output logic       ent_ready_o,
  input  blk_entry_t ent_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pixel_t     out_pix_o,
  output logic       out_last_o
);

  logic                 started_q;
  logic [PIX_N-1:0]     rem_q, rem, rem_next;
  logic [PIX_IDX_W-1:0] pix_idx;
  logic                 stage_free, go, emit;
  logic                 out_valid_q, out_last_q;
  pixel_t               out_pix_q, pix;
  logic [31:0]          sel;
  logic [1:0]           code;
  logic [3:0]           nib;
  logic [15:0]          e0, e1;

  assign rem = started_q ? rem_q : ent_i.mask;

  // lowest pending pixel first: row-major order
  always_comb begin
    pix_idx = '0;
    for (int i = PIX_N - 1; i >= 0; i--) begin
      if (rem[i]) pix_idx = PIX_IDX_W'(i);
    end
  end

  assign rem_next    = rem & ~(PIX_N'(1) << pix_idx);
  assign stage_free  = !out_valid_q || out_ready_i;
  assign go          = ent_valid_i && stage_free;
  assign emit        = go && (rem != '0);
  assign ent_ready_o = go && (rem_next == '0);

  assign e0   = ent_i.color_word[15:0];
  assign e1   = ent_i.color_word[31:16];
  assign sel  = ent_i.color_word[63:32];
  assign code = sel[{pix_idx, 1'b0} +: 2];
  assign nib  = ent_i.alpha_word[{pix_idx, 2'b00} +: 4];

  always_comb begin
    pix.pixel_x = {ent_i.blk_x, pix_idx[1:0]};
    pix.pixel_y = {ent_i.blk_y, pix_idx[3:2]};
    pix.red     = blend(code, widen5(e0[14:10]), widen5(e1[15:11]));
    pix.green   = blend(code, widen5(e0[9:5]),   widen6(e1[10:5]));
    pix.blue    = blend(code, widen5(e0[4:0]),   widen5(e1[4:0]));
    pix.alpha   = ent_i.rgba ? {nib, nib} : 8'hFF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (go) begin
        started_q <= rem_next != '0;
        rem_q     <= rem_next;
      end
      if (stage_free) begin
        out_valid_q <= emit;
      end
      if (emit) begin
        out_last_q <= rem_next == '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_pix_q <= pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> ent_valid_i)
    else $error("block head left the queue mid-block");

  a_pick_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> rem[pix_idx])
    else $error("emitted pixel not pending");

  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ent_valid_i && ent_ready_o && rem != '0) |=> (out_valid_q && out_last_q))
    else $error("block retired without a last pixel");

  a_mid_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> started_q)
    else $error("non-last pixel pending without an open block");
`endif

endmodule

### hw/rtl/atc_texture_block_decoder_top.sv
// ATC texture block decoder top level: config port, front end, queue, back end.
// Decodes one 4x4 ATC block per input transaction into up to sixteen pixel
// transactions, in raster block order (blocks left to right, then down; the walk
// wraps back to the first block after the last one). The output carries one pixel
// per cycle while the output is not stalled; a block wholly outside the image retires
// with no output. A taken block is written into the queue, and its first pixel is
// then registered in the back end's output stage from the queue head.
// A two-entry block queue lets the input take new blocks while the back end is
// still emitting pixels. Write configuration only while the block is idle.
module atc_texture_block_decoder_top import atc_tbd_pkg::*; #(
  parameter int unsigned MAX_IMAGE_DIM = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [2*WORD_W-1:0]  s_axis_tdata,   // color_word, alpha_word
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [$bits(pixel_t)-1:0] m_axis_tdata, // pixel_x, pixel_y, red, green, blue, alpha
  output logic                 m_axis_tlast
);

  logic       f_valid, f_ready, b_valid, b_ready;
  blk_entry_t f_ent, b_ent;
  pixel_t     out_pix;

  atc_tbd_front #(
    .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .color_word_i (s_axis_tdata[WORD_W-1:0]),
    .alpha_word_i (s_axis_tdata[2*WORD_W-1:WORD_W]),
    .ent_valid_o  (f_valid),
    .ent_ready_i  (f_ready),
    .ent_o        (f_ent)
  );

  atc_tbd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_ent),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_ent)
  );

  atc_tbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (b_valid),
    .ent_ready_o (b_ready),
    .ent_i       (b_ent),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (out_pix),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = out_pix;

endmodule

### tb/testbench.sv
// Self-checking testbench for the ATC texture block decoder top level.
`timescale 1ns / 100ps

module testbench;
  import atc_tbd_pkg::*;

  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned WDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYC = 16;

  typedef struct {
    pixel_t pix;
    logic   last;
  } exp_pixel_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [IDX_W-1:0]          cfg_idx_i = REG_RGBA_MODE;
  logic [CFG_W-1:0]          cfg_data_i = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [2*WORD_W-1:0]       s_axis_tdata = '0;   // color_word, alpha_word
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [$bits(pixel_t)-1:0] m_axis_tdata;        // pixel_x, pixel_y, red, green, blue, alpha
  logic                      m_axis_tlast;

  // predictor copy of the block's configuration and walk position
  logic        mdl_rgba;
  int unsigned mdl_width;
  int unsigned mdl_height;
  int unsigned blk_col;
  int unsigned blk_row;

  exp_pixel_t  pending_pixels[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned stall_left;
  bit          calm;

  atc_texture_block_decoder_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned mix_chan(logic [1:0] code, int unsigned a, int unsigned b);
    case (code)
      SEL_C0:    return a;
      SEL_THIRD: return (2 * a + b) / 3;
      SEL_MIX:   return (3 * a + 5 * b) / 8;
      default:   return b;
    endcase
  endfunction

  // Decode one block into the expected pixel list and step the block walk.
  function automatic void decode_block(logic [WORD_W-1:0] cw, logic [WORD_W-1:0] aw);
    int unsigned w, h, bx, by, px, py, n;
    int unsigned r0, g0, b0, r1, g1, b1;
    logic [4:0]  v5;
    logic [5:0]  v6;
    logic [1:0]  code;
    exp_pixel_t  e;
    w  = clamp_dim(mdl_width);
    h  = clamp_dim(mdl_height);
    bx = (w + 3) / 4;
    by = (h + 3) / 4;
    v5 = cw[14:10]; r0 = (v5 << 3) | (v5 >> 2);
    v5 = cw[9:5];   g0 = (v5 << 3) | (v5 >> 2);
    v5 = cw[4:0];   b0 = (v5 << 3) | (v5 >> 2);
    v5 = cw[31:27]; r1 = (v5 << 3) | (v5 >> 2);
    v6 = cw[26:21]; g1 = (v6 << 2) | (v6 >> 4);
    v5 = cw[20:16]; b1 = (v5 << 3) | (v5 >> 2);
    n  = 0;
    for (int p = 0; p < PIX_N; p++) begin
      px = blk_col * 4 + (p % 4);
      py = blk_row * 4 + (p / 4);
      if (px < w && py < h) begin
        code           = cw[32 + 2 * p +: 2];
        e.pix.pixel_x  = px[COORD_W-1:0];
        e.pix.pixel_y  = py[COORD_W-1:0];
        e.pix.red      = CHAN_W'(mix_chan(code, r0, r1));
        e.pix.green    = CHAN_W'(mix_chan(code, g0, g1));
        e.pix.blue     = CHAN_W'(mix_chan(code, b0, b1));
        e.pix.alpha    = mdl_rgba ? CHAN_W'(aw[4 * p +: 4] * 17) : 8'd255;
        e.last         = 1'b0;
        pending_pixels.push_back(e);
        n++;
      end
    end
    if (n > 0) pending_pixels[$].last = 1'b1;
    if (blk_col + 1 >= bx) begin
      blk_col = 0;
      blk_row = (blk_row + 1 >= by) ? 0 : blk_row + 1;
    end else begin
      blk_col++;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return 8191;
      2:       return MAX_DIM;
      3:       return $urandom_range(1, 8191);
      4:       return 1;
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_block(input logic [WORD_W-1:0] cw, input logic [WORD_W-1:0] aw);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {aw, cw};
    do @(posedge clk_i); while (!s_axis_tready);
    decode_block(cw, aw);
  endtask

  // Wait until every expected pixel is out, then let trailing empty blocks retire.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_config(input logic rgba, input int unsigned w, input int unsigned h);
    logic [CFG_W-1:0] wv, hv;
    wv = w[CFG_W-1:0];
    hv = h[CFG_W-1:0];
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_RGBA_MODE;
    cfg_data_i <= {{(CFG_W-1){1'b0}}, rgba};
    @(posedge clk_i);
    cfg_idx_i  <= REG_IMAGE_WIDTH;
    cfg_data_i <= wv;
    @(posedge clk_i);
    cfg_idx_i  <= REG_IMAGE_HEIGHT;
    cfg_data_i <= hv;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    mdl_rgba   = rgba;
    mdl_width  = 32'(wv);
    mdl_height = 32'(hv);
  endtask

  // Default geometry, opaque: endpoint extremes and each selector code.
  task automatic test_reset_geometry();
    logic [31:0] ends;
    ends = {16'h1FF4, 16'h7C0A};
    calm = 1'b1;
    send_block('0, '1);
    send_block('1, '0);
    send_block({32'h0000_0000, ends}, 64'h0123_4567_89AB_CDEF);
    send_block({32'h5555_5555, ends}, '1);
    send_block({32'hAAAA_AAAA, ends}, '0);
    send_block({32'hFFFF_FFFF, 16'h1FF4, 16'hFC0A}, '1);
  endtask

  // Small image with partial edge blocks and explicit alpha, through the wrap.
  task automatic test_alpha_edges();
    calm = 1'b0;
    set_config(1'b1, 6, 7);
    send_block({32'hE4E4_E4E4, 16'hF81F, 16'h03E0}, '0);
    send_block({32'h1B1B_1B1B, 16'h07E0, 16'h7C00}, '1);
    send_block('1, 64'h0123_4567_89AB_CDEF);
    send_block({32'h9C63_2D7A, 16'hFFFF, 16'h0000}, 64'hFEDC_BA98_7654_3210);
    send_block({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // Width and height of zero and above the maximum are clamped.
  task automatic test_dim_clamp();
    set_config(1'b0, 0, 0);
    send_block({$urandom, $urandom}, '1);
    send_block('1, '1);
    set_config(1'b1, 8191, 8191);
    send_block({$urandom, $urandom}, {$urandom, $urandom});
    send_block({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // Shrinking the image under the current walk position yields empty blocks.
  task automatic test_shrink();
    set_config(1'b0, MAX_DIM, MAX_DIM);
    send_block({$urandom, $urandom}, '0);
    send_block({$urandom, $urandom}, '0);
    set_config(1'b1, 8, MAX_DIM);
    send_block({$urandom, $urandom}, {$urandom, $urandom});
    send_block({$urandom, $urandom}, {$urandom, $urandom});
    send_block({$urandom, $urandom}, {$urandom, $urandom});
    set_config(1'b0, 8, 4);
    send_block({$urandom, $urandom}, '1);
    send_block({$urandom, $urandom}, '1);
  endtask

  task automatic test_random_walk();
    for (int ph = 0; ph < 9; ph++) begin
      calm = (ph % 3 == 0);
      set_config(1'($urandom_range(0, 1)), pick_dim(), pick_dim());
      for (int i = 0; i < 22; i++) send_block(pick_color(), {$urandom, $urandom});
    end
  endtask

  // Output side readiness: short random dips, occasional long stalls.
  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 31) == 0) begin
      stall_left    <= $urandom_range(8, 40);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Pixel checker
  always @(posedge clk_i) begin
    exp_pixel_t e;
    pixel_t     got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel transaction x=%0d y=%0d rgba=%02h%02h%02h%02h last=%0b",
                   got.pixel_x, got.pixel_y, got.red, got.green, got.blue, got.alpha,
                   m_axis_tlast);
      end else begin
        e = pending_pixels.pop_front();
        if (got !== e.pix || m_axis_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("pixel mismatch: exp x=%0d y=%0d rgba=%02h%02h%02h%02h last=%0b, ",
                   e.pix.pixel_x, e.pix.pixel_y, e.pix.red, e.pix.green, e.pix.blue,
                   e.pix.alpha, e.last);
            $display("got x=%0d y=%0d rgba=%02h%02h%02h%02h last=%0b",
                     got.pixel_x, got.pixel_y, got.red, got.green, got.blue, got.alpha,
                     m_axis_tlast);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mismatches  = 0;
    idle_cycles = 0;
    stall_left  = 0;
    calm        = 1'b1;
    mdl_rgba    = 1'b0;
    mdl_width   = MAX_DIM;
    mdl_height  = MAX_DIM;
    blk_col     = 0;
    blk_row     = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_alpha_edges();
    test_dim_clamp();
    test_shrink();
    test_random_walk();
    drain();
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/atc_tbd_pkg.sv
hw/rtl/atc_tbd_front.sv
hw/rtl/atc_tbd_fifo.sv
hw/rtl/atc_tbd_back.sv
hw/rtl/atc_texture_block_decoder_top.sv
tb/testbench.sv
